>>> design/sjfq_pkg.sv
// Shared constants, codes and controller/datapath interface types for the SJF ready queue.
package sjfq_pkg;

    localparam int DEPTH = 8;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] CMD_INSERT   = 2'd0;
    localparam logic [1:0] CMD_TICK     = 2'd1;
    localparam logic [1:0] CMD_DISPATCH = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic capture;
        logic exec;
        logic sort_step;
        logic sort_parity;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic             is_tick;
        logic [CNT_W-1:0] count;
    } dp_status_t;

endpackage

>>> design/sjfq_ctrl.sv
// Sequencer for the SJF ready queue: handshakes, operation steps and sort passes.
module sjfq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  sjfq_pkg::dp_status_t dp_stat,
    output sjfq_pkg::ctrl_cmd_t  dp_cmd
);
    import sjfq_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_SORT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] pass_reg, pass_next;
    logic             m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        pass_next    = pass_reg;
        m_valid_next = m_valid_reg;
        dp_cmd       = '0;
        dp_cmd.sort_parity = pass_reg[0];
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    dp_cmd.capture = 1'b1;
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                dp_cmd.exec = 1'b1;
                pass_next   = '0;
                state_next  = dp_stat.is_tick ? ST_SORT : ST_FINISH;
            end
            ST_SORT: begin
                // one odd-even transposition pass per cycle, count passes in all
                if (pass_reg == dp_stat.count) begin
                    state_next = ST_FINISH;
                end else begin
                    dp_cmd.sort_step = 1'b1;
                    pass_next        = pass_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    dp_cmd.load_out = 1'b1;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pass_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pass_reg    <= pass_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> design/sjfq_dp.sv
// Datapath for the SJF ready queue: table lanes, insert/dispatch/age logic, sort pass, result.
module sjfq_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  sjfq_pkg::ctrl_cmd_t  dp_cmd,
    output sjfq_pkg::dp_status_t dp_stat,
    input  logic [1:0]          s_command,
    input  logic [7:0]          s_job_id,
    input  logic [7:0]          s_burst,
    output logic [1:0]          m_status,
    output logic [7:0]          m_out_job_id,
    output logic [7:0]          m_out_burst,
    output logic [15:0]         m_out_wait,
    output logic [7:0]          m_out_effective,
    output logic [3:0]          m_occupancy
);
    import sjfq_pkg::*;

    logic [7:0]  id_reg    [DEPTH];
    logic [7:0]  id_next   [DEPTH];
    logic [7:0]  burst_reg [DEPTH];
    logic [7:0]  burst_next[DEPTH];
    logic [15:0] wait_reg  [DEPTH];
    logic [15:0] wait_next [DEPTH];
    logic [7:0]  eff_reg   [DEPTH];
    logic [7:0]  eff_next  [DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;

    logic [1:0] cmd_reg;
    logic [7:0] in_id_reg, in_burst_reg;

    logic [1:0]  res_status_reg, res_status_next;
    logic [7:0]  res_id_reg, res_id_next;
    logic [7:0]  res_burst_reg, res_burst_next;
    logic [15:0] res_wait_reg, res_wait_next;
    logic [7:0]  res_eff_reg, res_eff_next;

    logic [1:0]  m_status_reg;
    logic [7:0]  m_id_reg, m_burst_reg, m_eff_reg;
    logic [15:0] m_wait_reg;
    logic [3:0]  m_occ_reg;

    logic [DEPTH-1:0] le;
    logic [DEPTH-1:0] le_sh;
    logic [DEPTH-2:0] swap;
    logic [15:0]      aged_wait[DEPTH];
    logic [15:0]      aged_half[DEPTH];
    logic [7:0]       aged_eff [DEPTH];

    assign dp_stat.is_tick = (cmd_reg == CMD_TICK);
    assign dp_stat.count   = count_reg;

    // per-lane compares and aging
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            le[k] = (CNT_W'(k) < count_reg) && (eff_reg[k] <= in_burst_reg);
            aged_wait[k] = (wait_reg[k] != 16'hFFFF) ? wait_reg[k] + 16'd1 : wait_reg[k];
            aged_half[k] = aged_wait[k] >> 1;
            aged_eff[k]  = ({8'd0, burst_reg[k]} > aged_half[k])
                         ? burst_reg[k] - aged_half[k][7:0] : 8'd1;
        end
        le_sh = {le[DEPTH-2:0], 1'b1};
        for (int k = 0; k < DEPTH - 1; k++) begin
            swap[k] = (1'(k) == dp_cmd.sort_parity) && (CNT_W'(k + 1) < count_reg)
                    && (eff_reg[k] > eff_reg[k+1]);
        end
    end

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            id_next[k]    = id_reg[k];
            burst_next[k] = burst_reg[k];
            wait_next[k]  = wait_reg[k];
            eff_next[k]   = eff_reg[k];
        end
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_burst_next  = res_burst_reg;
        res_wait_next   = res_wait_reg;
        res_eff_next    = res_eff_reg;

        if (dp_cmd.exec) begin
            res_status_next = STAT_OK;
            res_id_next     = '0;
            res_burst_next  = '0;
            res_wait_next   = '0;
            res_eff_next    = '0;
            case (cmd_reg)
                CMD_INSERT: begin
                    if (count_reg >= CNT_W'(DEPTH)) begin
                        res_status_next = STAT_FULL;
                    end else begin
                        // entries past the insert point move up one lane
                        for (int k = 1; k < DEPTH; k++) begin
                            if (!le[k] && !le_sh[k]) begin
                                id_next[k]    = id_reg[k-1];
                                burst_next[k] = burst_reg[k-1];
                                wait_next[k]  = wait_reg[k-1];
                                eff_next[k]   = eff_reg[k-1];
                            end
                        end
                        for (int k = 0; k < DEPTH; k++) begin
                            if (!le[k] && le_sh[k]) begin
                                id_next[k]    = in_id_reg;
                                burst_next[k] = in_burst_reg;
                                wait_next[k]  = '0;
                                eff_next[k]   = in_burst_reg;
                            end
                        end
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_TICK: begin
                    for (int k = 0; k < DEPTH; k++) begin
                        wait_next[k] = aged_wait[k];
                        eff_next[k]  = aged_eff[k];
                    end
                end
                CMD_DISPATCH: begin
                    if (count_reg == '0) begin
                        res_status_next = STAT_EMPTY;
                    end else begin
                        res_id_next    = id_reg[0];
                        res_burst_next = burst_reg[0];
                        res_wait_next  = wait_reg[0];
                        res_eff_next   = eff_reg[0];
                        for (int k = 0; k < DEPTH - 1; k++) begin
                            id_next[k]    = id_reg[k+1];
                            burst_next[k] = burst_reg[k+1];
                            wait_next[k]  = wait_reg[k+1];
                            eff_next[k]   = eff_reg[k+1];
                        end
                        count_next = count_reg - 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (dp_cmd.sort_step) begin
            for (int k = 0; k < DEPTH - 1; k++) begin
                if (swap[k]) begin
                    id_next[k]      = id_reg[k+1];
                    id_next[k+1]    = id_reg[k];
                    burst_next[k]   = burst_reg[k+1];
                    burst_next[k+1] = burst_reg[k];
                    wait_next[k]    = wait_reg[k+1];
                    wait_next[k+1]  = wait_reg[k];
                    eff_next[k]     = eff_reg[k+1];
                    eff_next[k+1]   = eff_reg[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < DEPTH; k++) begin
            id_reg[k]    <= id_next[k];
            burst_reg[k] <= burst_next[k];
            wait_reg[k]  <= wait_next[k];
            eff_reg[k]   <= eff_next[k];
        end
        if (dp_cmd.capture) begin
            cmd_reg      <= s_command;
            in_id_reg    <= s_job_id;
            in_burst_reg <= s_burst;
        end
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_burst_reg  <= res_burst_next;
        res_wait_reg   <= res_wait_next;
        res_eff_reg    <= res_eff_next;
        if (dp_cmd.load_out) begin
            m_status_reg <= res_status_reg;
            m_id_reg     <= res_id_reg;
            m_burst_reg  <= res_burst_reg;
            m_wait_reg   <= res_wait_reg;
            m_eff_reg    <= res_eff_reg;
            m_occ_reg    <= 4'(count_reg);
        end
    end

    assign m_status        = m_status_reg;
    assign m_out_job_id    = m_id_reg;
    assign m_out_burst     = m_burst_reg;
    assign m_out_wait      = m_wait_reg;
    assign m_out_effective = m_eff_reg;
    assign m_occupancy     = m_occ_reg;

endmodule

>>> design/sjf_aging_ready_queue.sv
// Top level of the shortest-job-first ready queue with aging.
//
// Input channel (s_valid/s_ready) carries one command per transaction:
// insert a job (s_job_id, s_burst), age all entries, or dispatch the head.
// Every command yields exactly one result transaction on m_valid/m_ready:
// status, the dispatched job's fields (zero unless a job left the table)
// and the occupancy after the command.
// After the accepting edge, insert, dispatch and the spare code go through
// the EXEC and FINISH states before m_valid rises; an aging tick also runs
// SORT between them, one odd-even transposition pass per cycle and count
// passes in all, where count is the number of entries held.
// One command is worked on at a time; s_ready rises again as soon as the
// result has been handed to the output register, so the next command can be
// accepted while the previous result still waits to be taken.
// If the receiver stalls with a result pending, a finished command holds
// in place until the output register frees up.
// Reset (aresetn low, synchronous) empties the table and drops m_valid;
// no clearing pass is needed.
module sjf_aging_ready_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_job_id,
    input  logic [7:0]  s_burst,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_out_job_id,
    output logic [7:0]  m_out_burst,
    output logic [15:0] m_out_wait,
    output logic [7:0]  m_out_effective,
    output logic [3:0]  m_occupancy
);
    import sjfq_pkg::*;

    ctrl_cmd_t  dp_cmd;
    dp_status_t dp_stat;

    sjfq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dp_stat (dp_stat),
        .dp_cmd  (dp_cmd)
    );

    sjfq_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .dp_cmd          (dp_cmd),
        .dp_stat         (dp_stat),
        .s_command       (s_command),
        .s_job_id        (s_job_id),
        .s_burst         (s_burst),
        .m_status        (m_status),
        .m_out_job_id    (m_out_job_id),
        .m_out_burst     (m_out_burst),
        .m_out_wait      (m_out_wait),
        .m_out_effective (m_out_effective),
        .m_occupancy     (m_occupancy)
    );

endmodule
